// ===== design/ctpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_pkg: shared definitions for the camera tilt point correction unit
// Field widths, register indexes, reset values and fault codes.
// ----------------------------------------------------------------------------
package ctpc_pkg;

    localparam int COORD_W    = 16;
    localparam int TRIG_FRAC  = 14;
    localparam int FOCAL_W    = 20;
    localparam int COS_W      = TRIG_FRAC + 1;
    localparam int SIN_W      = TRIG_FRAC + 2;
    localparam int SEC_W      = TRIG_FRAC + 8;
    localparam int FAULT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    // The secant register is the widest one.
    localparam int CFG_DATA_W = SEC_W;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(16000);
    localparam logic [COS_W-1:0]   COS_RESET   = COS_W'(1) << TRIG_FRAC;
    localparam logic [SEC_W-1:0]   SEC_RESET   = SEC_W'(1) << TRIG_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILT_AXIS    = 3'd0,
        REG_CENTER_X     = 3'd1,
        REG_CENTER_Y     = 3'd2,
        REG_FOCAL_LENGTH = 3'd3,
        REG_COS_ANGLE    = 3'd4,
        REG_SIN_ANGLE    = 3'd5,
        REG_SEC_ANGLE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_OK      = 2'd0,
        FAULT_HORIZON = 2'd1,
        FAULT_SAT     = 2'd2
    } fault_t;

endpackage

// ===== design/ctpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_if: channel interfaces of the camera tilt point correction unit
// Point input, corrected result and register write channels.
// ----------------------------------------------------------------------------
interface ctpc_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctpc_pkg::COORD_W-1:0] point_x;
    logic signed [ctpc_pkg::COORD_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface ctpc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctpc_pkg::COORD_W-1:0] out_x;
    logic signed [ctpc_pkg::COORD_W-1:0] out_y;
    logic [ctpc_pkg::FAULT_W-1:0]        fault;

    modport source (output valid, output out_x, output out_y, output fault, input ready);
    modport sink (input valid, input out_x, input out_y, input fault, output ready);
endinterface

interface ctpc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ctpc_pkg::CFG_IDX_W-1:0]    index;
    logic [ctpc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/camera_tilt_point_correction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_tilt_point_correction_unit: tilt correction of one image point
// Scales the point's offsets from the optical centre by f/(f*cos + d*sin),
// with the secant on the tilt axis, through a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage:
// - cfg: register writes (index, data), always ready. Write only while no
//   point is in flight; the registers are read live by the stages that use them.
// - point: one word per source point. Ready is a registered signal and stays
//   high unless the output skid entry is occupied.
// - result: one word per point with corrected x, y and a fault code.
// Throughput is one point per cycle while the skid entry is empty; the divider
// spends one pipeline stage per quotient bit, 19 stages for both quotients side
// by side, and those set the depth. When the receiver stalls, the output
// register holds its word and one more word is caught in a skid entry; the
// pipeline then freezes as a whole and loses nothing. Reset empties the
// pipeline and loads the register defaults (pitch, centre 0, focal length
// 16000 pixels, zero angle).
// ----------------------------------------------------------------------------
module camera_tilt_point_correction_unit (
    input logic           clk,
    input logic           rst_n,
    ctpc_cfg_if.sink      cfg,
    ctpc_point_if.sink    point,
    ctpc_result_if.source result
);

    localparam int COORD_W   = ctpc_pkg::COORD_W;
    localparam int OFS_W     = COORD_W + 1;
    localparam int MAG_W     = COORD_W;
    localparam int FC_W      = ctpc_pkg::FOCAL_W + ctpc_pkg::COS_W;
    localparam int DS_W      = OFS_W + ctpc_pkg::SIN_W;
    localparam int DEN_W     = FC_W + 2;
    localparam int UDEN_W    = DEN_W - 1;
    localparam int DF_W      = MAG_W + ctpc_pkg::FOCAL_W;
    localparam int SEC_LO_W  = ctpc_pkg::SEC_W / 2;
    localparam int SEC_HI_W  = ctpc_pkg::SEC_W - SEC_LO_W;
    localparam int PLO_W     = DF_W + SEC_LO_W;
    localparam int PHI_W     = DF_W + SEC_HI_W;
    localparam int NUM_W     = DF_W + ctpc_pkg::SEC_W + 1;
    localparam int Q_W       = COORD_W + 3;
    localparam int HI_W      = NUM_W - Q_W;
    localparam int SUM_W     = Q_W + 1;

    localparam int S_IN      = 0;
    localparam int S_DIFF    = 1;
    localparam int S_MUL     = 2;
    localparam int S_DEN     = 3;
    localparam int S_NUM     = 4;
    localparam int S_PRE     = 5;
    localparam int S_OFF     = S_PRE + Q_W + 1;

    localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << (COORD_W + 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((2 ** (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (COORD_W - 1)));

    typedef struct packed {
        logic [UDEN_W-1:0] rem_a;
        logic [UDEN_W-1:0] rem_o;
        logic [Q_W-1:0]    nq_a;
        logic [Q_W-1:0]    nq_o;
        logic [UDEN_W-1:0] den;
        logic              den_ok;
        logic              ovf_a;
        logic              ovf_o;
        logic              zero_a;
        logic              zero_o;
        logic              neg_a;
        logic              neg_o;
    } div_t;

    typedef struct packed {
        logic [UDEN_W-1:0] rem;
        logic [Q_W-1:0]    nq;
    } step_t;

    typedef struct packed {
        logic                     sat;
        logic signed [COORD_W-1:0] val;
    } clamp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ctpc_pkg::FAULT_W-1:0] fault;
    } res_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The quotient bit enters at the bottom of the same shift register.
    function automatic step_t div_step(input logic [UDEN_W-1:0] rem,
                                       input logic [Q_W-1:0] nq,
                                       input logic [UDEN_W-1:0] den);
        logic [UDEN_W:0] trial;
        logic [UDEN_W:0] diff;
        step_t           r;
        trial = {rem, nq[Q_W-1]};
        diff  = trial - {1'b0, den};
        if (!diff[UDEN_W])
        begin
            r.rem = diff[UDEN_W-1:0];
            r.nq  = {nq[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[UDEN_W-1:0];
            r.nq  = {nq[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Beyond the horizon the offset runs to the limit unless the numerator is zero.
    function automatic logic signed [Q_W-1:0] signed_offset(input logic [Q_W-1:0] q,
                                                            input logic ovf,
                                                            input logic zero,
                                                            input logic den_ok,
                                                            input logic neg);
        logic [Q_W-1:0] m;
        if (!den_ok)
            m = zero ? '0 : Q_LIM;
        else if (ovf || (q > Q_LIM))
            m = Q_LIM;
        else
            m = q;
        return neg ? -signed'(m) : signed'(m);
    endfunction

    function automatic clamp_t clamp_coord(input logic signed [SUM_W-1:0] v);
        clamp_t r;
        r.sat = 1'b0;
        r.val = v[COORD_W-1:0];
        if (v > SUM_MAX)
        begin
            r.sat = 1'b1;
            r.val = SUM_MAX[COORD_W-1:0];
        end
        else if (v < SUM_MIN)
        begin
            r.sat = 1'b1;
            r.val = SUM_MIN[COORD_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                              tilt_axis_reg;
    logic signed [COORD_W-1:0]         center_x_reg;
    logic signed [COORD_W-1:0]         center_y_reg;
    logic [ctpc_pkg::FOCAL_W-1:0]      focal_reg;
    logic [ctpc_pkg::COS_W-1:0]        cos_reg;
    logic signed [ctpc_pkg::SIN_W-1:0] sin_reg;
    logic [ctpc_pkg::SEC_W-1:0]        sec_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_axis_reg <= 1'b0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            focal_reg     <= ctpc_pkg::FOCAL_RESET;
            cos_reg       <= ctpc_pkg::COS_RESET;
            sin_reg       <= '0;
            sec_reg       <= ctpc_pkg::SEC_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (ctpc_pkg::cfg_reg_t'(cfg.index))
                ctpc_pkg::REG_TILT_AXIS:    tilt_axis_reg <= cfg.data[0];
                ctpc_pkg::REG_CENTER_X:     center_x_reg  <= signed'(cfg.data[COORD_W-1:0]);
                ctpc_pkg::REG_CENTER_Y:     center_y_reg  <= signed'(cfg.data[COORD_W-1:0]);
                ctpc_pkg::REG_FOCAL_LENGTH: focal_reg     <= cfg.data[ctpc_pkg::FOCAL_W-1:0];
                ctpc_pkg::REG_COS_ANGLE:    cos_reg       <= cfg.data[ctpc_pkg::COS_W-1:0];
                ctpc_pkg::REG_SIN_ANGLE:    sin_reg       <= signed'(cfg.data[ctpc_pkg::SIN_W-1:0]);
                ctpc_pkg::REG_SEC_ANGLE:    sec_reg       <= cfg.data[ctpc_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipeline moves unless the skid is full.
    // ------------------------------------------------------------------
    logic [S_OFF:0] v_reg;
    logic           skid_valid_reg;
    logic           pipe_en;

    assign pipe_en     = !skid_valid_reg;
    assign point.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (pipe_en)
            v_reg <= {v_reg[S_OFF-1:0], point.valid};
    end

    // Input register
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;

    // Offsets from the centre along the tilt axis (d) and across it (e)
    logic signed [OFS_W-1:0] d_next, e_next, d_reg, e_reg;

    // Products
    logic [OFS_W-1:0]           d_abs, e_abs;
    logic [FC_W-1:0]            fc_reg;
    logic signed [DS_W-1:0]     ds_next, ds_reg;
    logic [DF_W-1:0]            df_next, ef_next, df_reg, ef_reg;
    logic                       neg_a_reg, neg_o_reg;

    // Denominator and secant partial products
    logic signed [DEN_W-1:0]    den_next, den_reg;
    logic [PLO_W-1:0]           pa_lo_reg;
    logic [PHI_W-1:0]           pa_hi_reg;
    logic [DF_W-1:0]            ef_d_reg;
    logic                       neg_a_d_reg, neg_o_d_reg;

    // Rounded numerators
    logic [UDEN_W-1:0]          uden, half;
    logic [NUM_W-1:0]           na_next, no_next, na_reg, no_reg;
    logic [UDEN_W-1:0]          uden_reg;
    logic                       den_ok_reg, zero_a_reg, zero_o_reg;
    logic                       neg_a_n_reg, neg_o_n_reg;

    // Divider: entry 0 is the setup stage, entry k holds k quotient bits.
    div_t div_reg  [Q_W+1];
    div_t div_next [Q_W+1];

    // Signed offsets
    logic signed [Q_W-1:0] off_a_next, off_o_next, off_a_reg, off_o_reg;
    logic                  den_ok_off_reg;

    always_comb
    begin
        if (tilt_axis_reg)
        begin
            d_next = OFS_W'(px_reg) - OFS_W'(center_x_reg);
            e_next = OFS_W'(py_reg) - OFS_W'(center_y_reg);
        end
        else
        begin
            d_next = OFS_W'(py_reg) - OFS_W'(center_y_reg);
            e_next = OFS_W'(px_reg) - OFS_W'(center_x_reg);
        end
    end

    always_comb
    begin
        d_abs   = d_reg[OFS_W-1] ? unsigned'(-d_reg) : unsigned'(d_reg);
        e_abs   = e_reg[OFS_W-1] ? unsigned'(-e_reg) : unsigned'(e_reg);
        ds_next = DS_W'(d_reg) * DS_W'(sin_reg);
        df_next = DF_W'(d_abs[MAG_W-1:0]) * DF_W'(focal_reg);
        ef_next = DF_W'(e_abs[MAG_W-1:0]) * DF_W'(focal_reg);
    end

    assign den_next = signed'(DEN_W'(fc_reg)) + DEN_W'(ds_reg);

    // Rounding to nearest adds half the denominator before the division.
    always_comb
    begin
        uden    = den_reg[UDEN_W-1:0];
        half    = uden >> 1;
        na_next = (NUM_W'(pa_hi_reg) << SEC_LO_W) + NUM_W'(pa_lo_reg) + NUM_W'(half);
        no_next = (NUM_W'(ef_d_reg) << ctpc_pkg::TRIG_FRAC) + NUM_W'(half);
    end

    always_comb
    begin
        div_next[0].rem_a  = na_reg[Q_W+UDEN_W-1:Q_W];
        div_next[0].rem_o  = no_reg[Q_W+UDEN_W-1:Q_W];
        div_next[0].nq_a   = na_reg[Q_W-1:0];
        div_next[0].nq_o   = no_reg[Q_W-1:0];
        div_next[0].den    = uden_reg;
        div_next[0].den_ok = den_ok_reg;
        // A quotient of 2^Q_W or more can only end up clamped.
        div_next[0].ovf_a  = na_reg[NUM_W-1:Q_W] >= HI_W'(uden_reg);
        div_next[0].ovf_o  = no_reg[NUM_W-1:Q_W] >= HI_W'(uden_reg);
        div_next[0].zero_a = zero_a_reg;
        div_next[0].zero_o = zero_o_reg;
        div_next[0].neg_a  = neg_a_n_reg;
        div_next[0].neg_o  = neg_o_n_reg;
        for (int k = 1; k <= Q_W; k++)
        begin
            step_t sa;
            step_t so;
            sa = div_step(div_reg[k-1].rem_a, div_reg[k-1].nq_a, div_reg[k-1].den);
            so = div_step(div_reg[k-1].rem_o, div_reg[k-1].nq_o, div_reg[k-1].den);
            div_next[k]       = div_reg[k-1];
            div_next[k].rem_a = sa.rem;
            div_next[k].nq_a  = sa.nq;
            div_next[k].rem_o = so.rem;
            div_next[k].nq_o  = so.nq;
        end
    end

    always_comb
    begin
        off_a_next = signed_offset(div_reg[Q_W].nq_a, div_reg[Q_W].ovf_a,
                                   div_reg[Q_W].zero_a, div_reg[Q_W].den_ok,
                                   div_reg[Q_W].neg_a);
        off_o_next = signed_offset(div_reg[Q_W].nq_o, div_reg[Q_W].ovf_o,
                                   div_reg[Q_W].zero_o, div_reg[Q_W].den_ok,
                                   div_reg[Q_W].neg_o);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            px_reg         <= point.point_x;
            py_reg         <= point.point_y;
            d_reg          <= d_next;
            e_reg          <= e_next;
            fc_reg         <= FC_W'(focal_reg) * FC_W'(cos_reg);
            ds_reg         <= ds_next;
            df_reg         <= df_next;
            ef_reg         <= ef_next;
            neg_a_reg      <= d_reg[OFS_W-1];
            neg_o_reg      <= e_reg[OFS_W-1];
            den_reg        <= den_next;
            pa_lo_reg      <= PLO_W'(df_reg) * PLO_W'(sec_reg[SEC_LO_W-1:0]);
            pa_hi_reg      <= PHI_W'(df_reg) * PHI_W'(sec_reg[ctpc_pkg::SEC_W-1:SEC_LO_W]);
            ef_d_reg       <= ef_reg;
            neg_a_d_reg    <= neg_a_reg;
            neg_o_d_reg    <= neg_o_reg;
            na_reg         <= na_next;
            no_reg         <= no_next;
            uden_reg       <= uden;
            den_ok_reg     <= !den_reg[DEN_W-1] && (den_reg != '0);
            zero_a_reg     <= (pa_lo_reg == '0) && (pa_hi_reg == '0);
            zero_o_reg     <= (ef_d_reg == '0);
            neg_a_n_reg    <= neg_a_d_reg;
            neg_o_n_reg    <= neg_o_d_reg;
            for (int k = 0; k <= Q_W; k++)
                div_reg[k] <= div_next[k];
            off_a_reg      <= off_a_next;
            off_o_reg      <= off_o_next;
            den_ok_off_reg <= div_reg[Q_W].den_ok;
        end
    end

    // ------------------------------------------------------------------
    // Centre add, clamp and output register with one skid entry
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] ca, co;
    logic signed [SUM_W-1:0]   sum_a, sum_o;
    clamp_t                    cl_a, cl_o;
    res_t                      res_next;

    always_comb
    begin
        ca = tilt_axis_reg ? center_x_reg : center_y_reg;
        co = tilt_axis_reg ? center_y_reg : center_x_reg;
        sum_a = SUM_W'(ca) + SUM_W'(off_a_reg);
        sum_o = SUM_W'(co) + SUM_W'(off_o_reg);
        cl_a  = clamp_coord(sum_a);
        cl_o  = clamp_coord(sum_o);
        res_next.x = tilt_axis_reg ? cl_a.val : cl_o.val;
        res_next.y = tilt_axis_reg ? cl_o.val : cl_a.val;
        if (!den_ok_off_reg)
            res_next.fault = ctpc_pkg::FAULT_HORIZON;
        else if (cl_a.sat || cl_o.sat)
            res_next.fault = ctpc_pkg::FAULT_SAT;
        else
            res_next.fault = ctpc_pkg::FAULT_OK;
    end

    logic out_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic push;

    assign push = v_reg[S_OFF] && pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !result.ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result.ready)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !result.ready)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.out_x = out_reg.x;
    assign result.out_y = out_reg.y;
    assign result.fault = out_reg.fault;

endmodule

// ===== sim/tb_camera_tilt_point_correction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_tilt_point_correction_unit: self-checking bench for tilt correction
// A table of directed points and register writes is followed by random phases
// of settings and points. Each word is checked against a table value or a local
// fixed-point predictor, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_camera_tilt_point_correction_unit;

    import ctpc_pkg::*;

    localparam int     HALF_PERIOD      = 6;
    localparam int     WATCHDOG_LIMIT   = 1000;
    localparam int     LONG_HOLD        = 150;
    localparam int     DRAIN_CYCLES     = 40;
    localparam int     PHASES           = 10;
    localparam int     POINTS_PER_PHASE = 70;
    localparam int     MAX_PRINTED      = 100;
    localparam real    PI               = 3.14159265358979;
    localparam real    TRIG_SCALE       = real'(1 << TRIG_FRAC);
    localparam longint COORD_MAX        = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN        = -COORD_MAX - 1;
    localparam logic [127:0] QUOT_LIMIT = 128'(1) << (COORD_W + 1);

    localparam logic signed [COORD_W-1:0] PT_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] PT_MAX = 16'sh7FFF;
    // No register sits at this index; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic [1:0] {STEP_WRITE, STEP_POINT, STEP_TYPED} step_kind_t;
    typedef enum int {CFG_REALISTIC, CFG_IN_RANGE, CFG_CORNERS, CFG_RAW} cfg_style_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        fault_t                    fault;
    } corrected_t;

    typedef struct packed {
        step_kind_t                kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] want_x;
        logic signed [COORD_W-1:0] want_y;
        fault_t                    want_fault;
    } step_t;

    localparam int N_DIRECTED = 40;
    localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
        // Reset settings give the identity.
        '{STEP_TYPED, 0, 0, 0, 0, 0, 0, FAULT_OK},
        '{STEP_TYPED, 0, 0, PT_MAX, PT_MAX, PT_MAX, PT_MAX, FAULT_OK},
        '{STEP_TYPED, 0, 0, PT_MIN, PT_MIN, PT_MIN, PT_MIN, FAULT_OK},
        '{STEP_TYPED, 0, 0, PT_MAX, PT_MIN, PT_MAX, PT_MIN, FAULT_OK},
        '{STEP_TYPED, 0, 0, PT_MIN, PT_MAX, PT_MIN, PT_MAX, FAULT_OK},
        '{STEP_TYPED, 0, 0, 1, -1, 1, -1, FAULT_OK},
        // Half cosine with no sine doubles both offsets.
        '{STEP_WRITE, REG_COS_ANGLE, 8192, 0, 0, 0, 0, FAULT_OK},
        '{STEP_TYPED, 0, 0, -3, 7, -6, 14, FAULT_OK},
        '{STEP_TYPED, 0, 0, 20000, 100, PT_MAX, 200, FAULT_SAT},
        '{STEP_TYPED, 0, 0, 100, -20000, 200, PT_MIN, FAULT_SAT},
        // Zero cosine and full sine: the denominator is the pitch offset.
        '{STEP_WRITE, REG_SIN_ANGLE, 16384, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_COS_ANGLE, 0, 0, 0, 0, 0, FAULT_OK},
        '{STEP_TYPED, 0, 0, 5, -16, PT_MAX, PT_MIN, FAULT_HORIZON},
        '{STEP_TYPED, 0, 0, 0, 0, 0, 0, FAULT_HORIZON},
        '{STEP_TYPED, 0, 0, -7, 0, PT_MIN, 0, FAULT_HORIZON},
        '{STEP_POINT, 0, 0, 5, 16, 0, 0, FAULT_OK},
        // Roll about a corner centre with a moderate angle.
        '{STEP_WRITE, REG_TILT_AXIS, 1, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_CENTER_X, 22'h3F8000, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_CENTER_Y, 32767, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_COS_ANGLE, 15826, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SIN_ANGLE, -4240, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SEC_ANGLE, 16962, 0, 0, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, PT_MAX, PT_MIN, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, PT_MIN, PT_MAX, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, 0, 0, 0, 0, FAULT_OK},
        // A zero focal length leaves both numerators at zero: the centre comes out.
        '{STEP_WRITE, REG_FOCAL_LENGTH, 0, 0, 0, 0, 0, FAULT_OK},
        '{STEP_TYPED, 0, 0, 100, 100, PT_MIN, PT_MAX, FAULT_HORIZON},
        '{STEP_TYPED, 0, 0, PT_MIN, 5, PT_MIN, PT_MAX, FAULT_HORIZON},
        // Register values beyond their stated ranges.
        '{STEP_WRITE, REG_UNMAPPED, 22'h3FFFFF, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_FOCAL_LENGTH, 1048575, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SEC_ANGLE, 4194303, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_COS_ANGLE, 32767, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SIN_ANGLE, 32767, 0, 0, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, 1234, -4321, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, PT_MAX, PT_MAX, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, PT_MIN, PT_MIN, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SEC_ANGLE, 0, 0, 0, 0, 0, FAULT_OK},
        '{STEP_WRITE, REG_SIN_ANGLE, 22'h8000, 0, 0, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, PT_MAX, 0, 0, 0, FAULT_OK},
        '{STEP_POINT, 0, 0, -1, 1, 0, 0, FAULT_OK}
    };

    logic clk;
    logic rst_n;

    ctpc_cfg_if    cfg_ch ();
    ctpc_point_if  point_ch ();
    ctpc_result_if result_ch ();

    camera_tilt_point_correction_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .point  (point_ch),
        .result (result_ch)
    );

    // Local copy of the register file, loaded with the reset values.
    bit                        axis_roll = 1'b0;
    logic signed [COORD_W-1:0] ctr_x     = '0;
    logic signed [COORD_W-1:0] ctr_y     = '0;
    logic [FOCAL_W-1:0]        focal     = FOCAL_RESET;
    logic [COS_W-1:0]          cosv      = COS_RESET;
    logic signed [SIN_W-1:0]   sinv      = '0;
    logic [SEC_W-1:0]          secv      = SEC_RESET;

    corrected_t corrected_q [$];
    int         mismatches    = 0;
    int         idle_cycles   = 0;
    bit         sender_eager   = 1'b0;
    bit         receiver_eager = 1'b0;
    bit         hold_request   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TILT_AXIS:    axis_roll = data[0];
            REG_CENTER_X:     ctr_x = data[COORD_W-1:0];
            REG_CENTER_Y:     ctr_y = data[COORD_W-1:0];
            REG_FOCAL_LENGTH: focal = data[FOCAL_W-1:0];
            REG_COS_ANGLE:    cosv = data[COS_W-1:0];
            REG_SIN_ANGLE:    sinv = data[SIN_W-1:0];
            REG_SEC_ANGLE:    secv = data[SEC_W-1:0];
            default: ;
        endcase
    endtask

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Centre plus the signed rounded quotient; beyond the horizon, the limit toward
    // the sign of the numerator, or the centre when the numerator is zero.
    function automatic longint place_coord(input longint centre, input bit neg,
                                           input logic [127:0] num, input longint den,
                                           output bit clipped);
        logic [127:0] q;
        longint       v;
        clipped = 1'b0;
        if (den <= 0)
            q = (num == 0) ? '0 : QUOT_LIMIT;
        else
        begin
            q = (num + 128'(den >>> 1)) / 128'(den);
            if (q > QUOT_LIMIT)
                q = QUOT_LIMIT;
        end
        v = neg ? centre - longint'(q) : centre + longint'(q);
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
            clipped = (den > 0);
        end
        else if (v < COORD_MIN)
        begin
            v = COORD_MIN;
            clipped = (den > 0);
        end
        return v;
    endfunction

    function automatic corrected_t correct_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py);
        longint       ca, co, d, e, den, ra, ro;
        logic [127:0] na, no;
        bit           clip_a, clip_o;
        corrected_t   r;
        if (axis_roll)
        begin
            ca = ctr_x;
            co = ctr_y;
            d  = longint'(px) - ca;
            e  = longint'(py) - co;
        end
        else
        begin
            ca = ctr_y;
            co = ctr_x;
            d  = longint'(py) - ca;
            e  = longint'(px) - co;
        end
        den = longint'(focal) * longint'(cosv) + d * longint'(sinv);
        na  = 128'(magnitude(d)) * 128'(secv) * 128'(focal);
        no  = (128'(magnitude(e)) * 128'(focal)) << TRIG_FRAC;
        ra  = place_coord(ca, d < 0, na, den, clip_a);
        ro  = place_coord(co, e < 0, no, den, clip_o);
        r.x = axis_roll ? ra[COORD_W-1:0] : ro[COORD_W-1:0];
        r.y = axis_roll ? ro[COORD_W-1:0] : ra[COORD_W-1:0];
        if (den <= 0)
            r.fault = FAULT_HORIZON;
        else if (clip_a || clip_o)
            r.fault = FAULT_SAT;
        else
            r.fault = FAULT_OK;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord(
        input logic signed [COORD_W-1:0] centre);
        case ($urandom_range(0, 4))
            0: return PT_MIN;
            1: return PT_MAX;
            2: return '0;
            3: return -1;
            default: return centre;
        endcase
    endfunction

    // Lowers the point valid and waits until every word sent has come back.
    task automatic wait_for_results();
        point_ch.valid <= 1'b0;
        while (corrected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic offer_point(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input bit typed, input corrected_t want);
        int gap;
        cfg_ch.valid <= 1'b0;
        gap = sender_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        @(posedge clk);
        while (point_ch.ready !== 1'b1)
            @(posedge clk);
        corrected_q.push_back(typed ? want : correct_point(px, py));
    endtask

    task automatic configure_phase(input cfg_style_t style);
        real                   rad;
        logic [CFG_DATA_W-1:0] tilt_v, cx_v, cy_v, f_v, c_v, s_v, sec_v;
        wait_for_results();
        tilt_v = $urandom_range(0, 1);
        case (style)
            CFG_REALISTIC:
            begin
                rad   = (real'($urandom_range(0, 1600)) / 10.0 - 80.0) * PI / 180.0;
                cx_v  = CFG_DATA_W'($urandom());
                cy_v  = CFG_DATA_W'($urandom());
                f_v   = $urandom_range(1000, 64000);
                c_v   = CFG_DATA_W'(int'($cos(rad) * TRIG_SCALE));
                s_v   = CFG_DATA_W'(int'($sin(rad) * TRIG_SCALE));
                sec_v = CFG_DATA_W'(int'(TRIG_SCALE / $cos(rad)));
            end
            CFG_IN_RANGE:
            begin
                cx_v  = $urandom_range(0, 65535);
                cy_v  = $urandom_range(0, 65535);
                f_v   = $urandom_range(1, 1048575);
                c_v   = $urandom_range(0, 16384);
                s_v   = CFG_DATA_W'(int'($urandom_range(0, 32768)) - 16384);
                sec_v = $urandom_range(16384, 4194303);
            end
            CFG_CORNERS:
            begin
                cx_v  = CFG_DATA_W'(corner_coord(PT_MAX));
                cy_v  = CFG_DATA_W'(corner_coord(PT_MIN));
                f_v   = $urandom_range(0, 1) ? 1 : 1048575;
                c_v   = $urandom_range(0, 1) ? 0 : 16384;
                s_v   = $urandom_range(0, 1) ? CFG_DATA_W'(-16384) : 16384;
                sec_v = $urandom_range(0, 1) ? 16384 : 4194303;
            end
            default:
            begin
                // Raw words: the upper bits above each register's width must be dropped.
                tilt_v = CFG_DATA_W'($urandom());
                cx_v   = CFG_DATA_W'($urandom());
                cy_v   = CFG_DATA_W'($urandom());
                f_v    = CFG_DATA_W'($urandom());
                c_v    = CFG_DATA_W'($urandom());
                s_v    = CFG_DATA_W'($urandom());
                sec_v  = CFG_DATA_W'($urandom());
            end
        endcase
        write_register(REG_TILT_AXIS, tilt_v);
        write_register(REG_CENTER_X, cx_v);
        write_register(REG_CENTER_Y, cy_v);
        write_register(REG_FOCAL_LENGTH, f_v);
        write_register(REG_COS_ANGLE, c_v);
        write_register(REG_SIN_ANGLE, s_v);
        write_register(REG_SEC_ANGLE, sec_v);
        if ($urandom_range(0, 1))
            write_register(REG_UNMAPPED, CFG_DATA_W'($urandom()));
    endtask

    always @(posedge clk)
    begin
        corrected_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_register(cfg_ch.index, cfg_ch.data);
            if (result_ch.valid && result_ch.ready)
            begin
                if (corrected_q.size() == 0)
                    report($sformatf("result word (%0d, %0d, fault %0d) with none expected",
                                     result_ch.out_x, result_ch.out_y, result_ch.fault));
                else
                begin
                    want = corrected_q.pop_front();
                    if (result_ch.out_x !== want.x)
                        report($sformatf("out_x %0d, predicted %0d", result_ch.out_x, want.x));
                    if (result_ch.out_y !== want.y)
                        report($sformatf("out_y %0d, predicted %0d", result_ch.out_y, want.y));
                    if (result_ch.fault !== want.fault)
                        report($sformatf("fault %0d, predicted %0d",
                                         result_ch.fault, want.fault));
                end
            end
            if ((cfg_ch.valid && cfg_ch.ready) || (point_ch.valid && point_ch.ready)
                || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** camera_tilt_point_correction_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: a random stall before each word unless eager, and one long hold-off on request.
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = receiver_eager ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    initial
    begin
        step_t                     row;
        logic signed [COORD_W-1:0] px, py;
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        point_ch.valid   <= 1'b0;
        point_ch.point_x <= '0;
        point_ch.point_y <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_STEPS[i];
            if (row.kind == STEP_WRITE)
            begin
                wait_for_results();
                write_register(row.idx, row.data);
            end
            else
                offer_point(row.px, row.py, row.kind == STEP_TYPED,
                            corrected_t'({row.want_x, row.want_y, row.want_fault}));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(cfg_style_t'(p % 4));
            sender_eager   = (p == 3 || p == 5 || p == 7);
            receiver_eager = (p == 3 || p == 7);
            // Back-to-back points against a stalled output fill the pipeline.
            if (p == 5)
                hold_request = 1'b1;
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        px = COORD_W'(int'(ctr_x) + int'($urandom_range(0, 4095)) - 2048);
                        py = COORD_W'(int'(ctr_y) + int'($urandom_range(0, 4095)) - 2048);
                    end
                    6, 7:
                    begin
                        px = COORD_W'($urandom());
                        py = COORD_W'($urandom());
                    end
                    default:
                    begin
                        px = corner_coord(ctr_x);
                        py = corner_coord(ctr_y);
                    end
                endcase
                offer_point(px, py, 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (corrected_q.size() != 0)
            report($sformatf("%0d result words never arrived", corrected_q.size()));
        if (mismatches == 0)
            $display("** camera_tilt_point_correction_unit: PASSED **");
        else
            $display("** camera_tilt_point_correction_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
design/ctpc_pkg.sv
design/ctpc_if.sv
design/camera_tilt_point_correction_unit.sv
sim/tb_camera_tilt_point_correction_unit.sv
